[rtl/value_to_rgb_colormap_top_defines.svh]
// assertion macros for the colour map block
`ifndef VALUE_TO_RGB_COLORMAP_TOP_DEFINES_SVH
`define VALUE_TO_RGB_COLORMAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VMAP_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define VMAP_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define VMAP_ASSERT_IMP(name, clk, rst_n, pre, post, msg)
`define VMAP_ASSERT_NXT(name, clk, rst_n, pre, post, msg)
`endif

`endif

[rtl/vmap_pkg.sv]
package vmap_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PC_W       = 3;
  localparam int FIELD_W    = 16;
  localparam int FRAC_BITS  = 15;
  localparam int CH_COUNT   = 3;
  localparam int BYTE_W     = 8;
  localparam int MIX_W      = 31;
  localparam int Y_W        = 40;
  localparam int DIV2_STEPS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE  = 3'd3;

  localparam logic [PC_W-1:0]    PC_MIN  = 3'd2;
  localparam logic [FIELD_W-1:0] ONE_Q15 = 16'd32768;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CH_COUNT-1:0][FIELD_W-1:0] colour_t;
  typedef logic [CH_COUNT-1:0][MIX_W-1:0] mixv_t;
  typedef logic [CH_COUNT-1:0][BYTE_W-1:0] rgb_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

[rtl/vmap_norm.sv]
module vmap_norm #(
  parameter int VB = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vmap_pkg::pipe_ctl_t      ctl,
  input  logic [VB-1:0]            sample,
  input  logic [VB-1:0]            lo,
  input  logic [VB-1:0]            hi,
  output logic                     out_vld,
  output vmap_pkg::field_t         frac
);

  localparam int STEPS = vmap_pkg::FRAC_BITS;

  logic [VB-1:0] s_r;
  logic          sv_r;

  logic [VB-1:0]                  rem_r [STEPS+1];
  logic [VB-1:0]                  dv_r  [STEPS+1];
  logic [vmap_pkg::FRAC_BITS-1:0] q_r   [STEPS+1];
  logic                           byp_r [STEPS+1];
  vmap_pkg::field_t               bv_r  [STEPS+1];
  logic                           v_r   [STEPS+1];

  logic [VB-1:0]                  rem_nxt [STEPS+1];
  logic [vmap_pkg::FRAC_BITS-1:0] q_nxt   [STEPS+1];
  logic                           byp_nxt;
  vmap_pkg::field_t               bv_nxt;

  // edge cases
  always_comb begin
    byp_nxt = 1'b1;
    bv_nxt  = '0;
    if (hi <= lo) begin
      bv_nxt = (s_r > lo) ? vmap_pkg::ONE_Q15 : '0;
    end else if (s_r <= lo) begin
      bv_nxt = '0;
    end else if (s_r >= hi) begin
      bv_nxt = vmap_pkg::ONE_Q15;
    end else begin
      byp_nxt = 1'b0;
    end
  end

  // operand set-up, then one restoring quotient bit per stage
  always_comb begin
    logic [VB:0] r2;
    r2 = '0;
    rem_nxt[0] = s_r - lo;
    q_nxt[0]   = '0;
    for (int j = 1; j <= STEPS; j++) begin
      r2 = {rem_r[j-1], 1'b0};
      if (r2 >= {1'b0, dv_r[j-1]}) begin
        rem_nxt[j] = VB'(r2 - {1'b0, dv_r[j-1]});
        q_nxt[j]   = {q_r[j-1][vmap_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt[j] = r2[VB-1:0];
        q_nxt[j]   = {q_r[j-1][vmap_pkg::FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      for (int j = 0; j <= STEPS; j++) v_r[j] <= 1'b0;
    end else if (ctl.en) begin
      sv_r   <= ctl.vld;
      v_r[0] <= sv_r;
      for (int j = 1; j <= STEPS; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s_r      <= sample;
      rem_r[0] <= rem_nxt[0];
      dv_r[0]  <= hi - lo;
      q_r[0]   <= q_nxt[0];
      byp_r[0] <= byp_nxt;
      bv_r[0]  <= bv_nxt;
      for (int j = 1; j <= STEPS; j++) begin
        rem_r[j] <= rem_nxt[j];
        dv_r[j]  <= dv_r[j-1];
        q_r[j]   <= q_nxt[j];
        byp_r[j] <= byp_r[j-1];
        bv_r[j]  <= bv_r[j-1];
      end
    end
  end

  assign out_vld = v_r[STEPS];
  assign frac    = byp_r[STEPS] ? bv_r[STEPS] : {1'b0, q_r[STEPS]};

endmodule

[rtl/vmap_seg.sv]
module vmap_seg #(
  parameter int MAX_POINTS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vmap_pkg::pipe_ctl_t   ctl,
  input  vmap_pkg::field_t      frac,
  input  vmap_pkg::field_t      pos [MAX_POINTS],
  input  vmap_pkg::colour_t     col [MAX_POINTS],
  input  logic [$clog2(MAX_POINTS)-1:0] cnt_last,
  output logic                  out_vld,
  output vmap_pkg::mixv_t       mix,
  output vmap_pkg::field_t      d_out
);

  localparam int UW = $clog2(MAX_POINTS);
  localparam int PW = 2 * vmap_pkg::FIELD_W;

  // stage 1: segment search
  logic [UW-1:0]    up_nxt;
  logic [UW-1:0]    up1_r;
  vmap_pkg::field_t frac1_r;
  logic             v1_r;

  always_comb begin
    up_nxt = cnt_last;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if ((UW'(i) < cnt_last) && (pos[i] >= frac)) up_nxt = UW'(i);
    end
  end

  // stage 2: weight numerator and denominator
  logic [UW-1:0]     lo_idx;
  vmap_pkg::field_t  pl;
  vmap_pkg::field_t  pu;
  vmap_pkg::field_t  nn;
  vmap_pkg::field_t  n_nxt;
  vmap_pkg::field_t  d_nxt;
  vmap_pkg::field_t  n2_r;
  vmap_pkg::field_t  d2_r;
  vmap_pkg::colour_t cl2_r;
  vmap_pkg::colour_t cu2_r;
  logic              v2_r;

  always_comb begin
    lo_idx = (up1_r == '0) ? '0 : up1_r - UW'(1);
    pl     = pos[lo_idx];
    pu     = pos[up1_r];
    nn     = (frac1_r > pl) ? frac1_r - pl : '0;
    if (up1_r == '0) begin
      n_nxt = '0;
      d_nxt = vmap_pkg::field_t'(1);
    end else if (pu <= pl) begin
      n_nxt = vmap_pkg::field_t'(1);
      d_nxt = vmap_pkg::field_t'(1);
    end else begin
      d_nxt = pu - pl;
      n_nxt = (nn > d_nxt) ? d_nxt : nn;
    end
  end

  // stage 3: weighted products
  logic [PW-1:0]    p1_r [vmap_pkg::CH_COUNT];
  logic [PW-1:0]    p2_r [vmap_pkg::CH_COUNT];
  vmap_pkg::field_t d3_r;
  logic             v3_r;
  vmap_pkg::field_t w;

  assign w = d2_r - n2_r;

  // stage 4: sum
  vmap_pkg::mixv_t  x4_r;
  vmap_pkg::field_t d4_r;
  logic             v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ctl.en) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      up1_r   <= up_nxt;
      frac1_r <= frac;
      n2_r    <= n_nxt;
      d2_r    <= d_nxt;
      cl2_r   <= col[lo_idx];
      cu2_r   <= col[up1_r];
      d3_r    <= d2_r;
      d4_r    <= d3_r;
      for (int c = 0; c < vmap_pkg::CH_COUNT; c++) begin
        p1_r[c] <= PW'(w) * PW'(cl2_r[c]);
        p2_r[c] <= PW'(n2_r) * PW'(cu2_r[c]);
        x4_r[c] <= vmap_pkg::MIX_W'(p1_r[c] + p2_r[c]);
      end
    end
  end

  assign out_vld = v4_r;
  assign mix     = x4_r;
  assign d_out   = d4_r;

endmodule

[rtl/vmap_mix_div.sv]
module vmap_mix_div (
  input  logic                clk,
  input  logic                rst_n,
  input  vmap_pkg::pipe_ctl_t ctl,
  input  vmap_pkg::mixv_t     mix,
  input  vmap_pkg::field_t    d,
  output logic                out_vld,
  output vmap_pkg::rgb_t      rgb
);

  localparam int STEPS = vmap_pkg::DIV2_STEPS;
  localparam int CH    = vmap_pkg::CH_COUNT;
  localparam int DDW   = 2 * vmap_pkg::FIELD_W;
  localparam int YW    = vmap_pkg::Y_W;

  logic [YW-1:0]               rem_r [STEPS+1][CH];
  logic [vmap_pkg::BYTE_W-1:0] q_r   [STEPS+1][CH];
  logic [DDW-1:0]              dd_r  [STEPS+1];
  logic                        v_r   [STEPS+1];

  logic [YW-1:0]               rem_nxt [STEPS+1][CH];
  logic [vmap_pkg::BYTE_W-1:0] q_nxt   [STEPS+1][CH];

  always_comb begin
    logic [YW-1:0] xw;
    logic [YW-1:0] trial;
    xw    = '0;
    trial = '0;
    // numerator 510*x + 32768*d, divisor 65536*d
    for (int c = 0; c < CH; c++) begin
      xw            = YW'(mix[c]);
      rem_nxt[0][c] = (xw << 9) - (xw << 1) + (YW'(d) << vmap_pkg::FRAC_BITS);
      q_nxt[0][c]   = '0;
    end
    // one quotient bit per stage, most significant first
    for (int j = 1; j <= STEPS; j++) begin
      trial = YW'(dd_r[j-1]) << (STEPS - j);
      for (int c = 0; c < CH; c++) begin
        if (rem_r[j-1][c] >= trial) begin
          rem_nxt[j][c] = rem_r[j-1][c] - trial;
          q_nxt[j][c]   = q_r[j-1][c] | (vmap_pkg::BYTE_W'(1) << (STEPS - j));
        end else begin
          rem_nxt[j][c] = rem_r[j-1][c];
          q_nxt[j][c]   = q_r[j-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= STEPS; j++) v_r[j] <= 1'b0;
    end else if (ctl.en) begin
      v_r[0] <= ctl.vld;
      for (int j = 1; j <= STEPS; j++) v_r[j] <= v_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dd_r[0] <= {d, {vmap_pkg::FIELD_W{1'b0}}};
      for (int j = 1; j <= STEPS; j++) dd_r[j] <= dd_r[j-1];
      for (int j = 0; j <= STEPS; j++) begin
        for (int c = 0; c < CH; c++) begin
          rem_r[j][c] <= rem_nxt[j][c];
          q_r[j][c]   <= q_nxt[j][c];
        end
      end
    end
  end

  assign out_vld = v_r[STEPS];

  always_comb begin
    for (int c = 0; c < CH; c++) rgb[c] = q_r[STEPS][c];
  end

endmodule

[rtl/value_to_rgb_colormap_top.sv]
// Piecewise-linear colour map: each sample request (unsigned Q16.16) is normalised
// against the minimum and maximum registers to a Q1.15 fraction, placed on a
// segment between up to MAX_POINTS colour control points and turned into rounded
// red, green and blue bytes. One sample is taken every clock while in_stall is low;
// each passes through the sample register and operand set-up stage, the 15-stage
// fraction divider, four stages of segment search and weighting, and the 9-stage
// colour byte divider. While a result is held by out_stall the whole pipeline
// freezes and in_stall is raised. The user must write configuration registers
// only while the pipeline is empty; the block itself does not enforce this.
`include "value_to_rgb_colormap_top_defines.svh"

module value_to_rgb_colormap_top #(
  parameter int MAX_POINTS  = 5,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vmap_pkg::SAMPLE_W-1:0]     in_sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vmap_pkg::BYTE_W-1:0]       out_red,
  output logic [vmap_pkg::BYTE_W-1:0]       out_green,
  output logic [vmap_pkg::BYTE_W-1:0]       out_blue,
  input  logic                              cfg_write_en,
  input  logic [vmap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vmap_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int VB = (SAMPLE_BITS < vmap_pkg::SAMPLE_W) ? SAMPLE_BITS : vmap_pkg::SAMPLE_W;
  localparam int UW = $clog2(MAX_POINTS);
  localparam logic [vmap_pkg::SAMPLE_W-1:0] MAX_RST = 32'd65536;
  localparam int FW = vmap_pkg::FIELD_W;
  localparam int CH = vmap_pkg::CH_COUNT;

  logic [vmap_pkg::PC_W-1:0]      pc_r;
  logic [VB-1:0]                  min_r;
  logic [VB-1:0]                  max_r;
  vmap_pkg::field_t               pos_r [MAX_POINTS];
  vmap_pkg::colour_t              col_r [MAX_POINTS];
  logic [vmap_pkg::CFG_IDX_W-1:0] pidx;

  function automatic vmap_pkg::field_t sat_field(input logic [FW-1:0] v);
    return (v > vmap_pkg::ONE_Q15) ? vmap_pkg::ONE_Q15 : v;
  endfunction

  assign pidx = cfg_index - vmap_pkg::REG_POINT_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= vmap_pkg::PC_MIN;
      min_r <= '0;
      max_r <= MAX_RST[VB-1:0];
      for (int i = 0; i < MAX_POINTS; i++) begin
        pos_r[i] <= '0;
        col_r[i] <= '0;
      end
    end else if (cfg_write_en) begin
      case (cfg_index)
        vmap_pkg::REG_POINT_COUNT: pc_r  <= cfg_data[vmap_pkg::PC_W-1:0];
        vmap_pkg::REG_VALUE_MIN:   min_r <= cfg_data[VB-1:0];
        vmap_pkg::REG_VALUE_MAX:   max_r <= cfg_data[VB-1:0];
        default: begin
          for (int i = 0; i < MAX_POINTS; i++) begin
            if (pidx == vmap_pkg::CFG_IDX_W'(i)) begin
              pos_r[i] <= sat_field(cfg_data[CH*FW +: FW]);
              for (int c = 0; c < CH; c++) begin
                col_r[i][c] <= sat_field(cfg_data[(CH-1-c)*FW +: FW]);
              end
            end
          end
        end
      endcase
    end
  end

  // count clamped to the supported range
  logic [vmap_pkg::PC_W-1:0] cnt_eff;
  logic [UW-1:0]             cnt_last;

  always_comb begin
    if (pc_r < vmap_pkg::PC_MIN) begin
      cnt_eff = vmap_pkg::PC_MIN;
    end else if (pc_r > vmap_pkg::PC_W'(MAX_POINTS)) begin
      cnt_eff = vmap_pkg::PC_W'(MAX_POINTS);
    end else begin
      cnt_eff = pc_r;
    end
    cnt_last = UW'(cnt_eff - vmap_pkg::PC_W'(1));
  end

  logic             en;
  logic             frac_vld;
  vmap_pkg::field_t frac;
  logic             seg_vld;
  vmap_pkg::mixv_t  mix_x;
  vmap_pkg::field_t seg_d;
  vmap_pkg::rgb_t   rgb;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  vmap_norm #(
    .VB (VB)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vmap_pkg::pipe_ctl_t'{en: en, vld: in_valid}),
    .sample  (in_sample_value[VB-1:0]),
    .lo      (min_r),
    .hi      (max_r),
    .out_vld (frac_vld),
    .frac    (frac)
  );

  vmap_seg #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (vmap_pkg::pipe_ctl_t'{en: en, vld: frac_vld}),
    .frac     (frac),
    .pos      (pos_r),
    .col      (col_r),
    .cnt_last (cnt_last),
    .out_vld  (seg_vld),
    .mix      (mix_x),
    .d_out    (seg_d)
  );

  vmap_mix_div u_mix_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vmap_pkg::pipe_ctl_t'{en: en, vld: seg_vld}),
    .mix     (mix_x),
    .d       (seg_d),
    .out_vld (out_valid),
    .rgb     (rgb)
  );

  assign out_red   = rgb[0];
  assign out_green = rgb[1];
  assign out_blue  = rgb[2];

  logic [vmap_pkg::MIX_W-1:0] mix_cap;
  logic                       frac_ok;
  logic                       mix_ok;
  logic                       frac_held;

  assign mix_cap   = {seg_d, {vmap_pkg::FRAC_BITS{1'b0}}};
  assign frac_ok   = frac <= vmap_pkg::ONE_Q15;
  assign mix_ok    = (seg_d != '0) && (mix_x[0] <= mix_cap) && (mix_x[1] <= mix_cap)
                     && (mix_x[2] <= mix_cap);
  assign frac_held = frac_vld && !en;

  `VMAP_ASSERT_IMP(a_frac_le_one, clk, rst_n, frac_vld, frac_ok, "fraction above one")
  `VMAP_ASSERT_IMP(a_mix_bound, clk, rst_n, seg_vld, mix_ok, "weighted mix out of range")
  `VMAP_ASSERT_NXT(a_frac_hold, clk, rst_n, frac_held, $stable(frac), "fraction moved in stall")

endmodule
